/* design/nnis_pkg.sv */
// Shared types and constants of the nearest-neighbor image scaler.
`default_nettype none

package nnis_pkg;

    localparam int PCT_SCALE   = 100;
    localparam int RECIP_SHIFT = 17;
    localparam int POS_W       = 10;
    localparam int PIX_W       = 24;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int N_W         = $clog2(((2 ** POS_W) - 1) * PCT_SCALE + 1);
    localparam int RCP_W       = RECIP_SHIFT + 1;
    localparam int RCP_RESET   = (2 ** RECIP_SHIFT) / PCT_SCALE;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [0:0] {
        OP_LOAD,
        OP_FETCH
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_W,
        CFG_SRC_H,
        CFG_TGT_W,
        CFG_TGT_H
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN
    } ratio_state_t;

    typedef enum logic [1:0] {
        PH_PCT_X,
        PH_PCT_Y,
        PH_RCP_X,
        PH_RCP_Y
    } ratio_phase_t;

    typedef struct packed {
        logic valid;
        logic fetch;
        logic outside;
        logic load_ok;
    } item_ctl_t;

endpackage

`default_nettype wire

/* design/nnis_ratio.sv */
// Shared restoring divider: axis percentages and their reciprocals after a config write.
`default_nettype none

module nnis_ratio #(
    parameter int SIZE_W = 11,
    parameter int PCT_W  = 17
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       go,
    input  wire logic [SIZE_W-1:0]          src_w,
    input  wire logic [SIZE_W-1:0]          src_h,
    input  wire logic [SIZE_W-1:0]          tgt_w,
    input  wire logic [SIZE_W-1:0]          tgt_h,
    output logic                            busy,
    output logic [PCT_W-1:0]                pct_x,
    output logic [PCT_W-1:0]                pct_y,
    output logic [nnis_pkg::RCP_W-1:0]      rcp_x,
    output logic [nnis_pkg::RCP_W-1:0]      rcp_y
);
    import nnis_pkg::*;

    localparam int DW    = (PCT_W > RCP_W) ? PCT_W : RCP_W;
    localparam int CNT_W = $clog2(DW);

    ratio_state_t        state_reg, state_next;
    ratio_phase_t        phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DW:0]         rem_reg;
    logic [DW-1:0]       quo_reg;
    logic [DW-1:0]       den_reg;
    logic [PCT_W-1:0]    pct_x_reg, pct_y_reg;
    logic [RCP_W-1:0]    rcp_x_reg, rcp_y_reg;

    logic                load_en, step_en, last_step;
    logic [DW-1:0]       dividend, divisor;
    logic [DW:0]         rem_sh, rem_step;
    logic [DW-1:0]       quo_step;
    logic                ge;

    assign last_step = (cnt_reg == CNT_W'(DW - 1));

    always_comb
    begin
        case (phase_reg)
            PH_PCT_X:
            begin
                dividend = DW'(tgt_w) * DW'(PCT_SCALE);
                divisor  = DW'(src_w);
            end
            PH_PCT_Y:
            begin
                dividend = DW'(tgt_h) * DW'(PCT_SCALE);
                divisor  = DW'(src_h);
            end
            PH_RCP_X:
            begin
                dividend = DW'(2 ** RECIP_SHIFT);
                divisor  = DW'(pct_x_reg);
            end
            PH_RCP_Y:
            begin
                dividend = DW'(2 ** RECIP_SHIFT);
                divisor  = DW'(pct_y_reg);
            end
            default:
            begin
                dividend = '0;
                divisor  = DW'(1);
            end
        endcase
    end

    assign rem_sh   = {rem_reg[DW-1:0], quo_reg[DW-1]};
    assign ge       = (rem_sh >= {1'b0, den_reg});
    assign rem_step = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    assign quo_step = {quo_reg[DW-2:0], ge};

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        if (go)
        begin
            state_next = ST_LOAD;
            phase_next = PH_PCT_X;
        end
        else
        begin
            case (state_reg)
                ST_IDLE: state_next = ST_IDLE;
                ST_LOAD: state_next = ST_RUN;
                ST_RUN:
                begin
                    if (last_step)
                    begin
                        case (phase_reg)
                            PH_PCT_X:
                            begin
                                state_next = ST_LOAD;
                                phase_next = PH_PCT_Y;
                            end
                            PH_PCT_Y:
                            begin
                                state_next = ST_LOAD;
                                phase_next = PH_RCP_X;
                            end
                            PH_RCP_X:
                            begin
                                state_next = ST_LOAD;
                                phase_next = PH_RCP_Y;
                            end
                            default: state_next = ST_IDLE;
                        endcase
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        busy    = 1'b0;
        load_en = 1'b0;
        step_en = 1'b0;
        case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_LOAD:
            begin
                busy    = 1'b1;
                load_en = 1'b1;
            end
            ST_RUN:
            begin
                busy    = 1'b1;
                step_en = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_PCT_X;
            cnt_reg   <= '0;
            pct_x_reg <= PCT_W'(PCT_SCALE);
            pct_y_reg <= PCT_W'(PCT_SCALE);
            rcp_x_reg <= RCP_W'(RCP_RESET);
            rcp_y_reg <= RCP_W'(RCP_RESET);
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (load_en)
            begin
                cnt_reg <= '0;
            end
            else if (step_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step && !go)
                begin
                    case (phase_reg)
                        PH_PCT_X: pct_x_reg <= (quo_step == '0) ? PCT_W'(1) : PCT_W'(quo_step);
                        PH_PCT_Y: pct_y_reg <= (quo_step == '0) ? PCT_W'(1) : PCT_W'(quo_step);
                        PH_RCP_X: rcp_x_reg <= RCP_W'(quo_step);
                        PH_RCP_Y: rcp_y_reg <= RCP_W'(quo_step);
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (step_en)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
    end

    assign pct_x = pct_x_reg;
    assign pct_y = pct_y_reg;
    assign rcp_x = rcp_x_reg;
    assign rcp_y = rcp_y_reg;

endmodule

`default_nettype wire

/* design/nnis_axis_index.sv */
// Four-stage pipeline: destination coordinate to clamped source index for one axis.
`default_nettype none

module nnis_axis_index #(
    parameter int PCT_W  = 17,
    parameter int SIZE_W = 11,
    parameter int IDX_W  = 10
) (
    input  wire logic                         clk,
    input  wire logic [nnis_pkg::POS_W-1:0]   pos,
    input  wire logic [PCT_W-1:0]             pct,
    input  wire logic [nnis_pkg::RCP_W-1:0]   rcp,
    input  wire logic [SIZE_W-1:0]            size,
    output logic [IDX_W-1:0]                  idx
);
    import nnis_pkg::*;

    localparam int PW  = N_W + RCP_W;
    localparam int MW  = N_W + PCT_W;
    localparam int CW  = (N_W > PCT_W) ? N_W : PCT_W;
    localparam int LW  = (N_W > SIZE_W) ? N_W : SIZE_W;

    logic [N_W-1:0]    n1_reg, n2_reg;
    logic [N_W-1:0]    q2_reg, q3_reg;
    logic [N_W-1:0]    r3_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [PW-1:0]     prod;
    logic [MW-1:0]     back;
    logic [N_W-1:0]    q_fix;
    logic [SIZE_W-1:0] lim;

    // quotient estimate is exact or one low; the remainder check fixes it
    assign prod  = PW'(n1_reg) * PW'(rcp);
    assign back  = MW'(q2_reg) * MW'(pct);
    assign q_fix = q3_reg + N_W'(CW'(r3_reg) >= CW'(pct));
    assign lim   = size - SIZE_W'(1);

    always_ff @(posedge clk)
    begin
        n1_reg  <= N_W'(pos) * N_W'(PCT_SCALE);
        q2_reg  <= prod[RECIP_SHIFT +: N_W];
        n2_reg  <= n1_reg;
        r3_reg  <= n2_reg - back[N_W-1:0];
        q3_reg  <= q2_reg;
        idx_reg <= (LW'(q_fix) > LW'(lim)) ? IDX_W'(lim) : IDX_W'(q_fix);
    end

    assign idx = idx_reg;

endmodule

`default_nettype wire

/* design/nnis_frame_mem.sv */
// Single-port source frame store with registered read data.
`default_nettype none

module nnis_frame_mem #(
    parameter int DEPTH  = 1048576,
    parameter int ADDR_W = 20
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [ADDR_W-1:0]            addr,
    input  wire logic [nnis_pkg::PIX_W-1:0]   wdata,
    output logic [nnis_pkg::PIX_W-1:0]        rdata
);
    import nnis_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/nearest_neighbor_image_scaler.sv */
// Top level of the nearest-neighbor image scaler: config, item pipeline and frame store.
//
//  port group          direction  handshake
//  start + fields      in         taken on a clock edge with start high and busy low
//  strobe + fields     out        one cycle per result, no back-pressure
//  cfg_we/index/data   in         written on any edge with cfg_we high
//
// One item per cycle while busy is low; fetch results leave in the order the items were taken.
// Loads write the store in the same stage where fetches read it, so order holds.
// A config write recomputes both percentages and reciprocals on one shared
// restoring divider, which keeps busy high until it is done. Reset gives
// percentages of 100 at once. The receiver cannot stall; the pipeline never holds.
`default_nettype none

module nearest_neighbor_image_scaler #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              operation,
    input  wire logic [nnis_pkg::POS_W-1:0]        pos_x,
    input  wire logic [nnis_pkg::POS_W-1:0]        pos_y,
    input  wire logic [nnis_pkg::PIX_W-1:0]        pixel_in,
    output logic                                   strobe,
    output logic [nnis_pkg::PIX_W-1:0]             pixel_out,
    output logic [nnis_pkg::POS_W-1:0]             source_col,
    output logic [nnis_pkg::POS_W-1:0]             source_row,
    output logic                                   outside,
    input  wire logic                              cfg_we,
    input  wire logic [nnis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nnis_pkg::CFG_W-1:0]        cfg_data
);
    import nnis_pkg::*;

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SIZE_W  = $clog2(MAX_DIM + 1);
    localparam int PCT_W   = $clog2(PCT_SCALE * MAX_DIM + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SW      = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
    localparam int PW      = (POS_W > SIZE_W) ? POS_W : SIZE_W;
    localparam int LAT     = 6;

    logic [CFG_W-1:0]  src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic [SIZE_W-1:0] src_w_eff, src_h_eff, tgt_w_eff, tgt_h_eff;

    logic [PCT_W-1:0]  pct_x, pct_y;
    logic [RCP_W-1:0]  rcp_x, rcp_y;

    logic              accept;
    item_ctl_t         ctl_in;
    item_ctl_t         ctl_reg [4];
    logic [POS_W-1:0]  px_reg  [4];
    logic [POS_W-1:0]  py_reg  [4];
    logic [PIX_W-1:0]  pix_reg [4];

    logic [COL_W-1:0]  col_idx, col5_reg;
    logic [ROW_W-1:0]  row_idx, row5_reg;
    item_ctl_t         ctl5_reg;

    logic [COL_W-1:0]  mem_col;
    logic [ROW_W-1:0]  mem_row;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [PIX_W-1:0]  mem_rdata;

    logic              strobe_reg;
    logic [PIX_W-1:0]  pixel_out_reg;
    logic [POS_W-1:0]  source_col_reg, source_row_reg;
    logic              outside_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= CFG_RESET;
            src_h_reg <= CFG_RESET;
            tgt_w_reg <= CFG_RESET;
            tgt_h_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SRC_W: src_w_reg <= cfg_data;
                CFG_SRC_H: src_h_reg <= cfg_data;
                CFG_TGT_W: tgt_w_reg <= cfg_data;
                CFG_TGT_H: tgt_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign src_w_eff = (src_w_reg == '0) ? SIZE_W'(1) :
                       (SW'(src_w_reg) > SW'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) :
                       SIZE_W'(src_w_reg);
    assign src_h_eff = (src_h_reg == '0) ? SIZE_W'(1) :
                       (SW'(src_h_reg) > SW'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) :
                       SIZE_W'(src_h_reg);
    assign tgt_w_eff = (SW'(tgt_w_reg) > SW'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) :
                       SIZE_W'(tgt_w_reg);
    assign tgt_h_eff = (SW'(tgt_h_reg) > SW'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) :
                       SIZE_W'(tgt_h_reg);

    nnis_ratio #(
        .SIZE_W (SIZE_W),
        .PCT_W  (PCT_W)
    ) u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cfg_we),
        .src_w (src_w_eff),
        .src_h (src_h_eff),
        .tgt_w (tgt_w_eff),
        .tgt_h (tgt_h_eff),
        .busy  (busy),
        .pct_x (pct_x),
        .pct_y (pct_y),
        .rcp_x (rcp_x),
        .rcp_y (rcp_y)
    );

    assign accept = start && !busy;

    always_comb
    begin
        ctl_in.valid   = accept;
        ctl_in.fetch   = (op_t'(operation) == OP_FETCH);
        ctl_in.outside = (PW'(pos_x) >= PW'(tgt_w_eff)) || (PW'(pos_y) >= PW'(tgt_h_eff));
        ctl_in.load_ok = (PW'(pos_x) < PW'(MAX_WIDTH)) && (PW'(pos_y) < PW'(MAX_HEIGHT));
    end

    // item control pipe, aligned with the index pipelines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                ctl_reg[i] <= '0;
            end
            ctl5_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < 4; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            ctl5_reg   <= ctl_reg[3];
            strobe_reg <= ctl5_reg.valid && ctl5_reg.fetch;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg[0]  <= pos_x;
        py_reg[0]  <= pos_y;
        pix_reg[0] <= pixel_in;
        for (int i = 1; i < 4; i++)
        begin
            px_reg[i]  <= px_reg[i-1];
            py_reg[i]  <= py_reg[i-1];
            pix_reg[i] <= pix_reg[i-1];
        end
    end

    nnis_axis_index #(
        .PCT_W  (PCT_W),
        .SIZE_W (SIZE_W),
        .IDX_W  (COL_W)
    ) u_index_x (
        .clk  (clk),
        .pos  (pos_x),
        .pct  (pct_x),
        .rcp  (rcp_x),
        .size (src_w_eff),
        .idx  (col_idx)
    );

    nnis_axis_index #(
        .PCT_W  (PCT_W),
        .SIZE_W (SIZE_W),
        .IDX_W  (ROW_W)
    ) u_index_y (
        .clk  (clk),
        .pos  (pos_y),
        .pct  (pct_y),
        .rcp  (rcp_y),
        .size (src_h_eff),
        .idx  (row_idx)
    );

    assign mem_col  = ctl_reg[3].fetch ? col_idx : COL_W'(px_reg[3]);
    assign mem_row  = ctl_reg[3].fetch ? row_idx : ROW_W'(py_reg[3]);
    assign mem_addr = ADDR_W'(mem_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(mem_col);
    assign mem_we   = ctl_reg[3].valid && !ctl_reg[3].fetch && ctl_reg[3].load_ok;

    nnis_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (pix_reg[3]),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk)
    begin
        col5_reg       <= col_idx;
        row5_reg       <= row_idx;
        pixel_out_reg  <= ctl5_reg.outside ? '0 : mem_rdata;
        source_col_reg <= ctl5_reg.outside ? '0 : POS_W'(col5_reg);
        source_row_reg <= ctl5_reg.outside ? '0 : POS_W'(row5_reg);
        outside_reg    <= ctl5_reg.outside;
    end

    assign strobe     = strobe_reg;
    assign pixel_out  = pixel_out_reg;
    assign source_col = source_col_reg;
    assign source_row = source_row_reg;
    assign outside    = outside_reg;

    a_cfg_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("config write did not start the ratio update");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy && (op_t'(operation) == OP_FETCH), LAT))
        else $error("result without a matching fetch item");

    a_pct_x_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !$past(busy)) |-> ($stable(pct_x) && $stable(rcp_x)))
        else $error("x ratio changed while idle");

    a_pct_y_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !$past(busy)) |-> ($stable(pct_y) && $stable(rcp_y)))
        else $error("y ratio changed while idle");

endmodule

`default_nettype wire

/* verif/tb_nearest_neighbor_image_scaler.sv */
// Self-checking testbench of the nearest-neighbor image scaler: directed rows, then random phases.
module tb_nearest_neighbor_image_scaler;
    import nnis_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int RAND_ITEMS   = 650;
    localparam int CALM_ITEMS   = 100;
    localparam int PHASE_ITEMS  = 60;
    localparam int FLUSH_CYCLES = 12;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             outside;
    } scaled_px_t;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_FETCH,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        cfg_idx_t         idx;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [PIX_W-1:0] data;
        logic             chk;
        scaled_px_t       res;
    } stim_row_t;

    localparam int N_ROWS = 25;
    localparam stim_row_t STIM_ROWS [N_ROWS] = '{
        '{ROW_LOAD,  CFG_SRC_W, 10'd0,    10'd0,    24'hFFFFFF, 1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd0,    10'd0,    24'h000000, 1'b1,
          '{24'hFFFFFF, 10'd0, 10'd0, 1'b0}},
        '{ROW_LOAD,  CFG_SRC_W, 10'd1023, 10'd1023, 24'h5A5A5A, 1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd1023, 10'd1023, 24'h000000, 1'b1,
          '{24'h5A5A5A, 10'd1023, 10'd1023, 1'b0}},
        '{ROW_LOAD,  CFG_SRC_W, 10'd5,    10'd3,    24'h123456, 1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd5,    10'd3,    24'h000000, 1'b1,
          '{24'h123456, 10'd5, 10'd3, 1'b0}},
        // zero target width: everything is outside
        '{ROW_CFG,   CFG_TGT_W, 10'd0,    10'd0,    24'd0,      1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd0,    10'd0,    24'h000000, 1'b1,
          '{24'h000000, 10'd0, 10'd0, 1'b1}},
        '{ROW_FETCH, CFG_SRC_W, 10'd1023, 10'd1023, 24'h000000, 1'b1,
          '{24'h000000, 10'd0, 10'd0, 1'b1}},
        // oversized target saturates to 1024
        '{ROW_CFG,   CFG_TGT_W, 10'd0,    10'd0,    24'd2047,   1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd1023, 10'd1023, 24'h000000, 1'b1,
          '{24'h5A5A5A, 10'd1023, 10'd1023, 1'b0}},
        // zero source width taken as 1
        '{ROW_CFG,   CFG_SRC_W, 10'd0,    10'd0,    24'd0,      1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd1023, 10'd3,    24'h000000, 1'b0, '0},
        '{ROW_CFG,   CFG_SRC_W, 10'd0,    10'd0,    24'd2047,   1'b0, '0},
        // percent floored at 1
        '{ROW_CFG,   CFG_TGT_H, 10'd0,    10'd0,    24'd1,      1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd7,    10'd0,    24'h000000, 1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd7,    10'd1,    24'h000000, 1'b1,
          '{24'h000000, 10'd0, 10'd0, 1'b1}},
        '{ROW_CFG,   CFG_SRC_H, 10'd0,    10'd0,    24'd1,      1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd1023, 10'd0,    24'h000000, 1'b0, '0},
        // index clamped to the source edge
        '{ROW_CFG,   CFG_TGT_W, 10'd0,    10'd0,    24'd700,    1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd699,  10'd0,    24'h000000, 1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd700,  10'd0,    24'h000000, 1'b1,
          '{24'h000000, 10'd0, 10'd0, 1'b1}},
        '{ROW_CFG,   CFG_SRC_H, 10'd0,    10'd0,    24'd1024,   1'b0, '0},
        '{ROW_CFG,   CFG_TGT_H, 10'd0,    10'd0,    24'd1024,   1'b0, '0},
        '{ROW_FETCH, CFG_SRC_W, 10'd5,    10'd3,    24'h000000, 1'b0, '0}
    };

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             operation;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] pixel_in;
    logic             strobe;
    logic [PIX_W-1:0] pixel_out;
    logic [POS_W-1:0] source_col;
    logic [POS_W-1:0] source_row;
    logic             outside;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    logic [PIX_W-1:0] frame_copy [int];
    logic [CFG_W-1:0] size_reg [4];
    scaled_px_t       pending_pixels [$];
    int               errors;
    int               items_taken;
    bit               idle_on;

    nearest_neighbor_image_scaler u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pixel_in   (pixel_in),
        .strobe     (strobe),
        .pixel_out  (pixel_out),
        .source_col (source_col),
        .source_row (source_row),
        .outside    (outside),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int size_eff(input logic [CFG_W-1:0] v, input int lo, input int hi);
        if (int'(v) < lo)
            return lo;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic int ratio_pct(input int tgt, input int src);
        int p;
        p = (PCT_SCALE * tgt) / src;
        return (p < 1) ? 1 : p;
    endfunction

    // returns the outside flag; col/row are the clamped source indexes
    function automatic bit source_point(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                        output int col, output int row);
        int sw;
        int sh;
        int tw;
        int th;
        sw  = size_eff(size_reg[CFG_SRC_W], 1, MAX_W);
        sh  = size_eff(size_reg[CFG_SRC_H], 1, MAX_H);
        tw  = size_eff(size_reg[CFG_TGT_W], 0, MAX_W);
        th  = size_eff(size_reg[CFG_TGT_H], 0, MAX_H);
        col = (int'(x) * PCT_SCALE) / ratio_pct(tw, sw);
        row = (int'(y) * PCT_SCALE) / ratio_pct(th, sh);
        if (col > sw - 1)
            col = sw - 1;
        if (row > sh - 1)
            row = sh - 1;
        return (int'(x) >= tw) || (int'(y) >= th);
    endfunction

    function automatic scaled_px_t scale_lookup(input logic [POS_W-1:0] x,
                                                input logic [POS_W-1:0] y);
        scaled_px_t r;
        int col;
        int row;
        r = '0;
        if (source_point(x, y, col, row))
            r.outside = 1'b1;
        else
        begin
            r.pix = frame_copy[row * MAX_W + col];
            r.col = POS_W'(col);
            r.row = POS_W'(row);
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    task automatic send_item(input op_t op, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [PIX_W-1:0] pix,
                             input bit chk, input scaled_px_t typed);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        operation <= op;
        pos_x     <= x;
        pos_y     <= y;
        pixel_in  <= pix;
        do
            @(posedge clk);
        while (busy);
        items_taken++;
        if (op == OP_LOAD)
            frame_copy[int'(y) * MAX_W + int'(x)] = pix;
        else
            pending_pixels.push_back(chk ? typed : scale_lookup(x, y));
    endtask

    // loads the sampled entry first when it was never written
    task automatic fetch_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                               input bit chk, input scaled_px_t typed);
        int col;
        int row;
        void'(source_point(x, y, col, row));
        if (!frame_copy.exists(row * MAX_W + col))
            send_item(OP_LOAD, POS_W'(col), POS_W'(row), PIX_W'($urandom), 1'b0, '0);
        send_item(OP_FETCH, x, y, PIX_W'($urandom), chk, typed);
    endtask

    task automatic settle_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        size_reg[idx] = v;
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return CFG_W'(0);
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            3:       return CFG_W'(1023);
            4:       return CFG_W'(1024);
            5:       return CFG_W'(1025);
            6:       return CFG_W'(2047);
            7:       return CFG_W'($urandom_range(0, 2047));
            default: return CFG_W'($urandom_range(1, 1024));
        endcase
    endfunction

    always @(posedge clk)
    begin
        scaled_px_t want;
        if (rst_n && strobe)
        begin
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, got %0h %0d %0d %0b",
                         $time, pixel_out, source_col, source_row, outside);
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_out", 32'(want.pix), 32'(pixel_out));
                check_field("source_col", 32'(want.col), 32'(source_col));
                check_field("source_row", 32'(want.row), 32'(source_row));
                check_field("outside", 32'(want.outside), 32'(outside));
            end
        end
    end

    initial
    begin
        logic [CFG_W-1:0] sz [4];
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        int stop_at;
        int phase;
        int tw;
        int th;
        errors      = 0;
        items_taken = 0;
        idle_on     = 1'b1;
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = 1'b0;
        pos_x       = '0;
        pos_y       = '0;
        pixel_in    = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        for (int i = 0; i < 4; i++)
            size_reg[i] = CFG_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
        begin
            case (STIM_ROWS[r].kind)
                ROW_LOAD:
                    send_item(OP_LOAD, STIM_ROWS[r].x, STIM_ROWS[r].y, STIM_ROWS[r].data,
                              1'b0, '0);
                ROW_FETCH:
                    fetch_pixel(STIM_ROWS[r].x, STIM_ROWS[r].y, STIM_ROWS[r].chk,
                                STIM_ROWS[r].res);
                default:
                begin
                    settle_idle();
                    write_reg(STIM_ROWS[r].idx, STIM_ROWS[r].data[CFG_W-1:0]);
                end
            endcase
        end

        stop_at = items_taken + RAND_ITEMS;
        phase   = 0;
        while (items_taken < stop_at)
        begin
            case (phase)
                0:       sz = '{CFG_W'(1),    CFG_W'(1),    CFG_W'(1024), CFG_W'(1024)};
                1:       sz = '{CFG_W'(1024), CFG_W'(1024), CFG_W'(1),    CFG_W'(1)};
                2:       sz = '{CFG_W'(2047), CFG_W'(2047), CFG_W'(0),    CFG_W'(0)};
                3:       sz = '{CFG_W'(0),    CFG_W'(0),    CFG_W'(2047), CFG_W'(2047)};
                4:       sz = '{CFG_W'(1024), CFG_W'(1024), CFG_W'(1024), CFG_W'(1024)};
                default: sz = '{pick_size(), pick_size(), pick_size(), pick_size()};
            endcase
            settle_idle();
            for (int i = 0; i < 4; i++)
                write_reg(cfg_idx_t'(i), sz[i]);
            tw = size_eff(size_reg[CFG_TGT_W], 0, MAX_W);
            th = size_eff(size_reg[CFG_TGT_H], 0, MAX_H);
            // the calm tail stays in one phase: no config writes, no pauses
            for (int k = 0;
                 (k < PHASE_ITEMS || items_taken >= stop_at - CALM_ITEMS)
                     && items_taken < stop_at;
                 k++)
            begin
                idle_on = (items_taken < stop_at - CALM_ITEMS);
                if (phase == 5 && k == PHASE_ITEMS / 2 && idle_on)
                    settle_idle();
                x = POS_W'($urandom_range(0, 1023));
                y = POS_W'($urandom_range(0, 1023));
                case ($urandom_range(0, 9))
                    0, 1:
                        send_item(OP_LOAD, x, y, PIX_W'($urandom), 1'b0, '0);
                    8, 9:
                        fetch_pixel(x, y, 1'b0, '0);
                    default:
                    begin
                        if (tw > 0)
                            x = POS_W'($urandom_range(0, tw - 1));
                        if (th > 0)
                            y = POS_W'($urandom_range(0, th - 1));
                        fetch_pixel(x, y, 1'b0, '0);
                    end
                endcase
            end
            phase++;
        end

        settle_idle();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
